// ===== design/pwe_pkg.sv =====
// Shared types and constants of the pulse width extractor.
// Used by every module of the block; depends on nothing else.
package pwe_pkg;

   localparam int THRESH_WIDTH = 16;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int LENGTH_WIDTH = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POLARITY = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESH_HIGH = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESH_LOW = 2'd3;

   // Detection modes.
   localparam logic MODE_ZERO_CROSS = 1'b0;
   localparam logic MODE_SCHMITT = 1'b1;

   localparam logic [THRESH_WIDTH-1:0] THRESH_HIGH_RESET = 16'sd1000;
   localparam logic [THRESH_WIDTH-1:0] THRESH_LOW_RESET = -16'sd1000;

   typedef struct packed {
      logic                           mode;
      logic                           polarity;
      logic signed [THRESH_WIDTH-1:0] thresh_hi;
      logic signed [THRESH_WIDTH-1:0] thresh_lo;
   } pwe_cfg_type;

   typedef struct packed {
      logic [LENGTH_WIDTH-1:0] pulse_length;
      logic                    pulse_level;
      logic                    truncated;
      logic                    config_error;
      logic                    last_of_run;
   } pwe_result_type;

   // Results of one request: how many, and up to two of them in order.
   typedef struct packed {
      logic [1:0]     count;
      pwe_result_type res0;
      pwe_result_type res1;
   } pwe_step_type;

endpackage

// ===== design/pwe_req_if.sv =====
// Request channel of the pulse width extractor: one sample per request.
// Depends on nothing else.
interface pwe_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink (input valid, input sample, input last_sample, output ready);
endinterface

// ===== design/pwe_rsp_if.sv =====
// Result channel of the pulse width extractor: one pulse per transfer.
// Depends on nothing else.
interface pwe_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pulse_length;
   logic        pulse_level;
   logic        truncated;
   logic        config_error;
   logic        last_of_run;

   modport source (output valid, output pulse_length, output pulse_level,
                   output truncated, output config_error, output last_of_run,
                   input ready);
   modport sink (input valid, input pulse_length, input pulse_level,
                 input truncated, input config_error, input last_of_run,
                 output ready);
endinterface

// ===== design/pwe_core.sv =====
// Level detector and run-length counter of the pulse width extractor.
// Depends on pwe_pkg for the configuration, result and step types.
module pwe_core #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic                           last_sample,
   input  pwe_pkg::pwe_cfg_type           cfg,
   output pwe_pkg::pwe_step_type          result
);

   localparam int CW = ((SAMPLE_WIDTH > pwe_pkg::THRESH_WIDTH) ?
                        SAMPLE_WIDTH : pwe_pkg::THRESH_WIDTH) + 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic signed [CW-1:0] S_ZERO = '0;

   logic                   level_ff, level_in;
   logic [COUNT_WIDTH-1:0] run_ff, run_in;
   logic                   settled_ff, settled_in;
   logic                   buffer_start_ff, buffer_start_in;

   logic                   lvl0;
   logic [COUNT_WIDTH-1:0] run0;
   logic [COUNT_WIDTH-1:0] run_bump;
   logic                   set0;
   logic signed [CW-1:0]   s_ext, th_ext, tl_ext, hi, lo;
   logic                   zc_level;
   logic                   invalid;
   logic                   done;
   logic [COUNT_WIDTH-1:0] done_len;
   logic                   done_lvl;
   logic                   lvl_mid;
   logic [COUNT_WIDTH-1:0] run_mid;
   logic                   set_mid;
   pwe_pkg::pwe_result_type done_res, end_res, err_res;

   // The first sample of a buffer sees cleared state.
   assign lvl0 = buffer_start_ff ? 1'b0 : level_ff;
   assign run0 = buffer_start_ff ? '0 : run_ff;
   assign set0 = buffer_start_ff ? 1'b0 : settled_ff;
   assign run_bump = (run0 == COUNT_MAX) ? run0 : run0 + 1'b1;

   assign s_ext = {{(CW-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
   assign th_ext = {{(CW-pwe_pkg::THRESH_WIDTH){cfg.thresh_hi[pwe_pkg::THRESH_WIDTH-1]}},
                    cfg.thresh_hi};
   assign tl_ext = {{(CW-pwe_pkg::THRESH_WIDTH){cfg.thresh_lo[pwe_pkg::THRESH_WIDTH-1]}},
                    cfg.thresh_lo};
   assign hi = cfg.polarity ? -tl_ext : th_ext;
   assign lo = cfg.polarity ? -th_ext : tl_ext;
   assign invalid = (cfg.mode == pwe_pkg::MODE_SCHMITT) && (hi <= lo);
   assign zc_level = cfg.polarity ? (s_ext <= S_ZERO) : (s_ext >= S_ZERO);

   always_comb begin
      done = 1'b0;
      done_len = run0;
      done_lvl = lvl0;
      lvl_mid = lvl0;
      run_mid = run_bump;
      set_mid = set0;
      if (cfg.mode == pwe_pkg::MODE_ZERO_CROSS) begin
         if (buffer_start_ff) begin
            lvl_mid = zc_level;
            run_mid = COUNT_WIDTH'(1);
         end else if (zc_level != lvl0) begin
            done = 1'b1;
            lvl_mid = zc_level;
            run_mid = COUNT_WIDTH'(1);
         end
      end else if (invalid) begin
         // Ignored sample: nothing is counted.
         run_mid = run0;
      end else if (!set0) begin
         if (s_ext >= hi || s_ext <= lo) begin
            set_mid = 1'b1;
            lvl_mid = (s_ext >= hi);
            run_mid = COUNT_WIDTH'(1);
         end
      end else if ((lvl0 && s_ext <= lo) || (!lvl0 && s_ext >= hi)) begin
         done = 1'b1;
         lvl_mid = ~lvl0;
         run_mid = COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      done_res.pulse_length = 32'(done_len);
      done_res.pulse_level = done_lvl;
      done_res.truncated = 1'b0;
      done_res.config_error = 1'b0;
      done_res.last_of_run = ~last_sample;

      end_res.pulse_length = 32'(run_mid);
      end_res.pulse_level = lvl_mid;
      end_res.truncated = 1'b1;
      end_res.config_error = 1'b0;
      end_res.last_of_run = 1'b1;

      err_res.pulse_length = '0;
      err_res.pulse_level = 1'b0;
      err_res.truncated = 1'b0;
      err_res.config_error = 1'b1;
      err_res.last_of_run = 1'b1;

      result.res1 = end_res;
      if (invalid) begin
         result.count = {1'b0, last_sample};
         result.res0 = err_res;
      end else if (done) begin
         result.count = last_sample ? 2'd2 : 2'd1;
         result.res0 = done_res;
      end else begin
         result.count = {1'b0, last_sample};
         result.res0 = end_res;
      end
   end

   always_comb begin
      buffer_start_in = last_sample;
      if (last_sample) begin
         level_in = 1'b0;
         run_in = '0;
         settled_in = 1'b0;
      end else begin
         level_in = lvl_mid;
         run_in = run_mid;
         settled_in = set_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         run_ff <= '0;
         settled_ff <= 1'b0;
         buffer_start_ff <= 1'b1;
      end else if (step) begin
         level_ff <= level_in;
         run_ff <= run_in;
         settled_ff <= settled_in;
         buffer_start_ff <= buffer_start_in;
      end
   end

endmodule

// ===== design/pwe_out_fifo.sv =====
// Two-entry result queue of the pulse width extractor; takes up to two
// results per cycle and hands out one. Depends on pwe_pkg.
module pwe_out_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_count,
   input  pwe_pkg::pwe_result_type push0,
   input  pwe_pkg::pwe_result_type push1,
   input  logic                    pop,
   output logic [1:0]              free,
   output logic                    head_valid,
   output pwe_pkg::pwe_result_type head
);

   pwe_pkg::pwe_result_type entry_ff [2];
   pwe_pkg::pwe_result_type entry_in [2];
   logic [1:0]              count_ff, count_in;
   logic [1:0]              count_kept;

   assign head_valid = (count_ff != 2'd0);
   assign head = entry_ff[0];
   assign count_kept = count_ff - {1'b0, pop};
   assign free = 2'd2 - count_kept;
   assign count_in = count_kept + push_count;

   // Entry 0 is always the oldest; a pop shifts entry 1 down.
   always_comb begin
      entry_in[0] = pop ? entry_ff[1] : entry_ff[0];
      entry_in[1] = entry_ff[1];
      if (push_count != 2'd0) begin
         entry_in[count_kept[0]] = push0;
      end
      if (push_count == 2'd2) begin
         entry_in[1] = push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
   end

endmodule

// ===== design/pulse_width_extractor.sv =====
// Top level of the pulse width extractor: input register, configuration
// registers, level detector and result queue. Depends on pwe_pkg,
// pwe_req_if, pwe_rsp_if, pwe_core and pwe_out_fifo.
//
//   channel    direction  carries
//   req_chan   in         sample, last_sample
//   rsp_chan   out        pulse_length, pulse_level, truncated,
//                         config_error, last_of_run
//   csr_*      in         csr_we, csr_index, csr_wdata (write only)
//
// A request is registered at acceptance and moves into the result queue once
// the queue has room for all of its results; its first result is offered
// from then on. One request per cycle is sustained while the queue has room;
// results leave at one per cycle, so a request with two results can hold
// the request side. Synchronous reset clears the pulse state and
// the queue and sets the registers to their defaults. A stalled result side
// backs up through the two-entry queue into the request side.
module pulse_width_extractor #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pwe_req_if.sink                               req_chan,
   pwe_rsp_if.source                             rsp_chan,
   input  logic                                  csr_we,
   input  logic [pwe_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pwe_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   pwe_pkg::pwe_cfg_type           cfg_ff;
   logic                           in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           last_ff;
   logic                           step;
   logic                           pop;
   logic [1:0]                     free;
   logic                           head_valid;
   pwe_pkg::pwe_step_type          step_res;
   pwe_pkg::pwe_result_type        head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= pwe_pkg::MODE_ZERO_CROSS;
         cfg_ff.polarity <= 1'b0;
         cfg_ff.thresh_hi <= pwe_pkg::THRESH_HIGH_RESET;
         cfg_ff.thresh_lo <= pwe_pkg::THRESH_LOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pwe_pkg::CSR_MODE: begin
               cfg_ff.mode <= csr_wdata[0];
            end
            pwe_pkg::CSR_POLARITY: begin
               cfg_ff.polarity <= csr_wdata[0];
            end
            pwe_pkg::CSR_THRESH_HIGH: begin
               cfg_ff.thresh_hi <= csr_wdata[pwe_pkg::THRESH_WIDTH-1:0];
            end
            pwe_pkg::CSR_THRESH_LOW: begin
               cfg_ff.thresh_lo <= csr_wdata[pwe_pkg::THRESH_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The registered request moves on once the queue has room for all of
   // its results.
   assign step = in_valid_ff && (step_res.count <= free);
   assign req_chan.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         sample_ff <= req_chan.sample;
         last_ff <= req_chan.last_sample;
      end
   end

   pwe_core #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .sample      (sample_ff),
      .last_sample (last_ff),
      .cfg         (cfg_ff),
      .result      (step_res)
   );

   assign pop = head_valid && rsp_chan.ready;

   pwe_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (step ? step_res.count : 2'd0),
      .push0      (step_res.res0),
      .push1      (step_res.res1),
      .pop        (pop),
      .free       (free),
      .head_valid (head_valid),
      .head       (head)
   );

   assign rsp_chan.valid = head_valid;
   assign rsp_chan.pulse_length = head.pulse_length;
   assign rsp_chan.pulse_level = head.pulse_level;
   assign rsp_chan.truncated = head.truncated;
   assign rsp_chan.config_error = head.config_error;
   assign rsp_chan.last_of_run = head.last_of_run;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for pulse_width_extractor: a directed table, then random
// buffers under several register settings, checked against a pulse tracker or the table.
// Depends on pwe_pkg, pwe_req_if, pwe_rsp_if and the block itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_WIDTH = 16;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 500000;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 140;
   localparam int LONG_HOLD = 120;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                            kind;
      logic [pwe_pkg::CSR_INDEX_WIDTH-1:0]     index;
      logic signed [SAMPLE_WIDTH-1:0]          value;
      logic                                    last;
      logic                                    typed;
      pwe_pkg::pwe_result_type                 want;
   } directed_row_type;

   localparam pwe_pkg::pwe_result_type NO_PULSE = '0;
   localparam pwe_pkg::pwe_result_type END_HIGH_ONE = '{32'd1, 1'b1, 1'b1, 1'b0, 1'b1};
   localparam pwe_pkg::pwe_result_type END_LOW_ONE = '{32'd1, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam pwe_pkg::pwe_result_type THRESH_ERROR = '{32'd0, 1'b0, 1'b0, 1'b1, 1'b1};

   localparam logic signed [SAMPLE_WIDTH-1:0] SET_SCHMITT = 16'(pwe_pkg::MODE_SCHMITT);
   localparam logic signed [SAMPLE_WIDTH-1:0] SET_ZERO_CROSS = 16'(pwe_pkg::MODE_ZERO_CROSS);

   localparam int N_DIRECTED = 30;

   // Zero-crossing edges, inverted polarity, Schmitt settling and switching,
   // a buffer that never crosses, bad thresholds, and extreme thresholds.
   directed_row_type directed_rows [0:N_DIRECTED-1] = '{
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd0, 1'b1, 1'b1, END_HIGH_ONE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sh8000, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sh8000, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd32767, 1'b1, 1'b0, NO_PULSE},
      '{ROW_CSR, pwe_pkg::CSR_POLARITY, 16'sd1, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd0, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd1, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, -16'sd1, 1'b1, 1'b0, NO_PULSE},
      '{ROW_CSR, pwe_pkg::CSR_MODE, SET_SCHMITT, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd0, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd999, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd1000, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, -16'sd999, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, -16'sd1000, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd0, 1'b1, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd5, 1'b1, 1'b1, END_LOW_ONE},
      '{ROW_CSR, pwe_pkg::CSR_POLARITY, 16'sd0, 1'b0, 1'b0, NO_PULSE},
      '{ROW_CSR, pwe_pkg::CSR_THRESH_HIGH, -16'sd32767, 1'b0, 1'b0, NO_PULSE},
      '{ROW_CSR, pwe_pkg::CSR_THRESH_LOW, 16'sd32767, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd123, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sh8000, 1'b1, 1'b1, THRESH_ERROR},
      '{ROW_CSR, pwe_pkg::CSR_THRESH_HIGH, 16'sd32767, 1'b0, 1'b0, NO_PULSE},
      '{ROW_CSR, pwe_pkg::CSR_THRESH_LOW, -16'sd32767, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd32767, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sh8000, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, -16'sd32767, 1'b1, 1'b0, NO_PULSE},
      '{ROW_CSR, pwe_pkg::CSR_THRESH_HIGH, 16'sd0, 1'b0, 1'b0, NO_PULSE},
      '{ROW_CSR, pwe_pkg::CSR_THRESH_LOW, 16'sd0, 1'b0, 1'b0, NO_PULSE},
      '{ROW_SAMPLE, pwe_pkg::CSR_MODE, 16'sd7, 1'b1, 1'b1, THRESH_ERROR},
      '{ROW_CSR, pwe_pkg::CSR_MODE, SET_ZERO_CROSS, 1'b0, 1'b0, NO_PULSE}
   };

   logic clock;
   logic reset;
   logic                                  csr_we;
   logic [pwe_pkg::CSR_INDEX_WIDTH-1:0]   csr_index;
   logic [pwe_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata;

   pwe_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_chan ();
   pwe_rsp_if rsp_chan ();

   pulse_width_extractor #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COUNT_WIDTH(32)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Tracker copy of the registers and of the pulse state.
   logic                               cfg_mode;
   logic                               cfg_polarity;
   logic signed [15:0]                 cfg_thr_high;
   logic signed [15:0]                 cfg_thr_low;
   logic                               level_q;
   logic [pwe_pkg::LENGTH_WIDTH-1:0]   run_q;
   logic                               settled_q;
   logic                               buf_start_q;

   pwe_pkg::pwe_result_type pulse_queue [$];
   pwe_pkg::pwe_result_type step_pulses [$];

   int  mismatch_count = 0;
   int  pulses_seen = 0;
   int  cycle_count = 0;
   bit  sender_quiet = 1'b0;
   bit  receiver_quiet = 1'b0;
   bit  tone_q = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // Effective Schmitt bounds: inverted polarity swaps and negates them.
   function automatic void schmitt_bounds(output int hi, output int lo);
      hi = cfg_polarity ? -int'(cfg_thr_low) : int'(cfg_thr_high);
      lo = cfg_polarity ? -int'(cfg_thr_high) : int'(cfg_thr_low);
   endfunction

   // Advances the pulse state by one sample and leaves its pulses in step_pulses.
   function automatic void track_pulse(input logic signed [15:0] s, input logic last);
      int                               hi;
      int                               lo;
      logic                             zc_lvl;
      logic                             first;
      logic                             done;
      logic [pwe_pkg::LENGTH_WIDTH-1:0] done_len;
      logic                             done_level;
      step_pulses.delete();
      first = buf_start_q;
      done = 1'b0;
      done_len = '0;
      done_level = 1'b0;
      if (first) begin
         settled_q = 1'b0;
         level_q = 1'b0;
         run_q = '0;
      end
      buf_start_q = last;
      if (cfg_mode == pwe_pkg::MODE_ZERO_CROSS) begin
         zc_lvl = cfg_polarity ? (s <= 0) : (s >= 0);
         if (first) begin
            level_q = zc_lvl;
            run_q = 1;
         end else if (zc_lvl != level_q) begin
            done = 1'b1;
            done_len = run_q;
            done_level = level_q;
            level_q = zc_lvl;
            run_q = 1;
         end else if (run_q != '1) begin
            run_q++;
         end
      end else begin
         schmitt_bounds(hi, lo);
         if (hi <= lo) begin
            // Bad thresholds: the sample is not counted, and the buffer end
            // gives the error result in place of the end pulse.
            if (last) begin
               step_pulses.push_back(THRESH_ERROR);
               run_q = '0;
               level_q = 1'b0;
               settled_q = 1'b0;
            end
            return;
         end
         if (!settled_q) begin
            if (s >= hi || s <= lo) begin
               settled_q = 1'b1;
               level_q = (s >= hi);
               run_q = 1;
            end else if (run_q != '1) begin
               run_q++;
            end
         end else if ((level_q && s <= lo) || (!level_q && s >= hi)) begin
            done = 1'b1;
            done_len = run_q;
            done_level = level_q;
            level_q = !level_q;
            run_q = 1;
         end else if (run_q != '1) begin
            run_q++;
         end
      end
      if (done)
         step_pulses.push_back('{done_len, done_level, 1'b0, 1'b0, !last});
      if (last) begin
         step_pulses.push_back('{run_q, level_q, 1'b1, 1'b0, 1'b1});
         run_q = '0;
         level_q = 1'b0;
         settled_q = 1'b0;
      end
   endfunction

   function automatic logic signed [15:0] pick_sample();
      int hi;
      int lo;
      int v;
      if ($urandom_range(0, 5) == 0)
         tone_q = !tone_q;
      schmitt_bounds(hi, lo);
      case ($urandom_range(0, 9))
         0: v = int'($signed(16'($urandom)));
         1: v = tone_q ? 32767 : -32768;
         2, 3: v = int'($urandom_range(0, 6)) - 3;
         4, 5: v = (tone_q ? hi : lo) + int'($urandom_range(0, 4)) - 2;
         default: v = tone_q ? int'($urandom_range(0, 32767)) :
                              -int'($urandom_range(1, 32768));
      endcase
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return 16'(v);
   endfunction

   task automatic send_sample(input logic signed [15:0] s, input logic last,
                              input logic typed, input pwe_pkg::pwe_result_type want);
      int gap;
      if ($urandom_range(0, 39) == 0)
         sender_quiet = !sender_quiet;
      gap = sender_quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= s;
      req_chan.last_sample <= last;
      do @(posedge clock); while (!req_chan.ready);
      track_pulse(s, last);
      if (typed)
         pulse_queue.push_back(want);
      else
         foreach (step_pulses[i]) pulse_queue.push_back(step_pulses[i]);
   endtask

   // Registers change only with nothing in flight; samples that give no
   // pulse may still sit in the pipeline, hence the extra cycles.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pulse_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [pwe_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [pwe_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         pwe_pkg::CSR_MODE: cfg_mode = data[0];
         pwe_pkg::CSR_POLARITY: cfg_polarity = data[0];
         pwe_pkg::CSR_THRESH_HIGH: cfg_thr_high = data;
         pwe_pkg::CSR_THRESH_LOW: cfg_thr_low = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Result side: random stalls per pulse, quiet stretches, and two long
   // hold-offs that back the block up into its request side.
   initial begin
      int                      stall_left;
      pwe_pkg::pwe_result_type got;
      pwe_pkg::pwe_result_type want;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.pulse_length, rsp_chan.pulse_level, rsp_chan.truncated,
                    rsp_chan.config_error, rsp_chan.last_of_run};
            pulses_seen++;
            if (pulse_queue.size() == 0) begin
               report_mismatch($sformatf("pulse with nothing expected: %p", got));
            end else begin
               want = pulse_queue.pop_front();
               if (got.pulse_length != want.pulse_length)
                  report_mismatch($sformatf("pulse_length %0d, expected %0d",
                                            got.pulse_length, want.pulse_length));
               if (got.pulse_level != want.pulse_level)
                  report_mismatch($sformatf("pulse_level %b, expected %b",
                                            got.pulse_level, want.pulse_level));
               if (got.truncated != want.truncated)
                  report_mismatch($sformatf("truncated %b, expected %b",
                                            got.truncated, want.truncated));
               if (got.config_error != want.config_error)
                  report_mismatch($sformatf("config_error %b, expected %b",
                                            got.config_error, want.config_error));
               if (got.last_of_run != want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, expected %b",
                                            got.last_of_run, want.last_of_run));
            end
            if ($urandom_range(0, 39) == 0)
               receiver_quiet = !receiver_quiet;
            stall_left = receiver_quiet ? 0 : $urandom_range(0, 5);
            if (pulses_seen == 150 || pulses_seen == 700)
               stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin
      int   buffer_left;
      int   pick;
      int   th;
      int   tl;
      logic last;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.sample <= '0;
      req_chan.last_sample <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      cfg_mode = pwe_pkg::MODE_ZERO_CROSS;
      cfg_polarity = 1'b0;
      cfg_thr_high = pwe_pkg::THRESH_HIGH_RESET;
      cfg_thr_low = pwe_pkg::THRESH_LOW_RESET;
      level_q = 1'b0;
      run_q = '0;
      settled_q = 1'b0;
      buf_start_q = 1'b1;
      buffer_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_drained();
            csr_write(directed_rows[r].index, directed_rows[r].value);
         end else begin
            send_sample(directed_rows[r].value, directed_rows[r].last,
                        directed_rows[r].typed, directed_rows[r].want);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         pick = $urandom_range(0, 7);
         if (pick == 0) begin
            // High threshold at or below the low one.
            tl = $urandom_range(0, 20000);
            th = tl - int'($urandom_range(0, 100));
         end else if (pick == 1) begin
            th = 32767;
            tl = -32767;
         end else begin
            th = $urandom_range(1, 12000);
            tl = th - int'($urandom_range(1, 20000));
         end
         csr_write(pwe_pkg::CSR_MODE,
                   {15'b0, ($urandom_range(0, 3) != 0) ? pwe_pkg::MODE_SCHMITT :
                                                         pwe_pkg::MODE_ZERO_CROSS});
         csr_write(pwe_pkg::CSR_POLARITY, {15'b0, 1'($urandom_range(0, 1))});
         csr_write(pwe_pkg::CSR_THRESH_HIGH, 16'(th));
         csr_write(pwe_pkg::CSR_THRESH_LOW, 16'(tl));
         // Buffers may run across a phase boundary on purpose.
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (buffer_left == 0)
               buffer_left = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150) :
                                                           $urandom_range(1, 24);
            last = (buffer_left == 1);
            buffer_left--;
            send_sample(pick_sample(), last, 1'b0, NO_PULSE);
         end
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/pwe_pkg.sv
design/pwe_req_if.sv
design/pwe_rsp_if.sv
design/pwe_core.sv
design/pwe_out_fifo.sv
design/pulse_width_extractor.sv
sim/tb_top.sv
